FILE: src/cau_pkg.sv
package cau_pkg;

    localparam int FRAC_BITS = 16;
    localparam int OP_W      = 3;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int MAG_W     = PROD_W;
    localparam int DEN_W     = PROD_W;
    localparam int Q_BITS    = DATA_W + 1;
    localparam int NUM_W     = MAG_W + FRAC_BITS;
    localparam int CMP_W     = DEN_W + Q_BITS + 1 + FRAC_BITS;

    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV = 3'd3;
    localparam logic [OP_W-1:0] OP_CMP = 3'd4;

    localparam logic [MAG_W-1:0] POS_LIM = MAG_W'(64'h7FFF_FFFF);
    localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(64'h8000_0000);

    // Sums and denominator after the multiplier stages
    typedef struct packed {
        logic                    valid;
        logic [OP_W-1:0]         func;
        logic signed [SUM_W-1:0] s_re;
        logic signed [SUM_W-1:0] s_im;
        logic [DEN_W-1:0]        den;
        logic                    eq;
    } front_t;

    // One stage of the quotient pipeline
    typedef struct packed {
        logic              valid;
        logic              is_div;
        logic              dz;
        logic              eq;
        logic              neg_re;
        logic              neg_im;
        logic              big_re;
        logic              big_im;
        logic [DEN_W-1:0]  den;
        logic [NUM_W-1:0]  rem_re;
        logic [NUM_W-1:0]  rem_im;
        logic [Q_BITS-1:0] q_re;
        logic [Q_BITS-1:0] q_im;
    } step_t;

    // Clamp a sign/magnitude value to 32 bits; msb is the overflow flag
    function automatic logic [DATA_W:0] saturate(input logic neg, input logic [MAG_W-1:0] mag);
        logic [MAG_W-1:0] m;
        logic             ovf;
        logic [MAG_W-1:0] v;
        begin
            ovf = 1'b0;
            m = mag;
            if (neg)
            begin
                if (m > NEG_LIM)
                begin
                    m = NEG_LIM;
                    ovf = 1'b1;
                end
                v = MAG_W'(0) - m;
            end
            else
            begin
                if (m > POS_LIM)
                begin
                    m = POS_LIM;
                    ovf = 1'b1;
                end
                v = m;
            end
            return {ovf, v[DATA_W-1:0]};
        end
    endfunction

endpackage

FILE: src/cau_front.sv
module cau_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [cau_pkg::OP_W-1:0]      func,
    input  logic signed [cau_pkg::DATA_W-1:0] a_re,
    input  logic signed [cau_pkg::DATA_W-1:0] a_im,
    input  logic signed [cau_pkg::DATA_W-1:0] b_re,
    input  logic signed [cau_pkg::DATA_W-1:0] b_im,
    output cau_pkg::front_t               out
);

    logic                                 v1_reg;
    logic [cau_pkg::OP_W-1:0]             func1_reg;
    logic signed [cau_pkg::DATA_W-1:0]    a1_reg, b1_reg, c1_reg, d1_reg;
    logic signed [cau_pkg::PROD_W-1:0]    ac_reg, bd_reg, ad_reg, bc_reg, cc_reg, dd_reg;
    cau_pkg::front_t                      f_reg;
    cau_pkg::front_t                      f_next;
    logic [cau_pkg::DEN_W-1:0]            den;

    // Stage 1: all partial products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            func1_reg <= func;
            a1_reg    <= a_re;
            b1_reg    <= a_im;
            c1_reg    <= b_re;
            d1_reg    <= b_im;
            ac_reg    <= a_re * b_re;
            bd_reg    <= a_im * b_im;
            ad_reg    <= a_re * b_im;
            bc_reg    <= a_im * b_re;
            cc_reg    <= b_re * b_re;
            dd_reg    <= b_im * b_im;
        end
    end

    // Stage 2: pick the sums for the operation
    always_comb
    begin
        den = cau_pkg::DEN_W'(cc_reg) + cau_pkg::DEN_W'(dd_reg);
        f_next.valid = v1_reg;
        f_next.func  = func1_reg;
        f_next.den   = den;
        f_next.eq    = (func1_reg == cau_pkg::OP_CMP) && (a1_reg == c1_reg)
                       && (b1_reg == d1_reg);
        f_next.s_re  = '0;
        f_next.s_im  = '0;
        case (func1_reg)
            cau_pkg::OP_ADD:
            begin
                f_next.s_re = cau_pkg::SUM_W'(a1_reg) + cau_pkg::SUM_W'(c1_reg);
                f_next.s_im = cau_pkg::SUM_W'(b1_reg) + cau_pkg::SUM_W'(d1_reg);
            end
            cau_pkg::OP_SUB:
            begin
                f_next.s_re = cau_pkg::SUM_W'(a1_reg) - cau_pkg::SUM_W'(c1_reg);
                f_next.s_im = cau_pkg::SUM_W'(b1_reg) - cau_pkg::SUM_W'(d1_reg);
            end
            cau_pkg::OP_MUL:
            begin
                f_next.s_re = cau_pkg::SUM_W'(ac_reg) - cau_pkg::SUM_W'(bd_reg);
                f_next.s_im = cau_pkg::SUM_W'(ad_reg) + cau_pkg::SUM_W'(bc_reg);
            end
            cau_pkg::OP_DIV:
            begin
                if (den != '0)
                begin
                    f_next.s_re = cau_pkg::SUM_W'(ac_reg) + cau_pkg::SUM_W'(bd_reg);
                    f_next.s_im = cau_pkg::SUM_W'(bc_reg) - cau_pkg::SUM_W'(ad_reg);
                end
            end
            default:
            begin
                f_next.s_re = '0;
                f_next.s_im = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            f_reg <= f_next;
        end
    end

    assign out = f_reg;

endmodule

FILE: src/cau_div.sv
module cau_div (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  cau_pkg::front_t in,
    output cau_pkg::step_t  out
);

    cau_pkg::step_t          st_reg [0:cau_pkg::Q_BITS];
    cau_pkg::step_t          prep_next;
    logic                    neg_re, neg_im;
    logic [cau_pkg::SUM_W-1:0] abs_re, abs_im;
    logic [cau_pkg::MAG_W-1:0] mag_re, mag_im;
    logic                    div_ok;
    logic [cau_pkg::CMP_W-1:0] lim;

    // Prepare: sign/magnitude, scale, and the quotient range check
    always_comb
    begin
        neg_re = in.s_re < 0;
        neg_im = in.s_im < 0;
        abs_re = neg_re ? cau_pkg::SUM_W'(-in.s_re) : cau_pkg::SUM_W'(in.s_re);
        abs_im = neg_im ? cau_pkg::SUM_W'(-in.s_im) : cau_pkg::SUM_W'(in.s_im);
        mag_re = abs_re[cau_pkg::MAG_W-1:0];
        mag_im = abs_im[cau_pkg::MAG_W-1:0];
        div_ok = (in.func == cau_pkg::OP_DIV) && (in.den != '0);
        lim    = cau_pkg::CMP_W'(in.den) << cau_pkg::Q_BITS;

        prep_next.valid  = in.valid;
        prep_next.is_div = div_ok;
        prep_next.dz     = (in.func == cau_pkg::OP_DIV) && (in.den == '0);
        prep_next.eq     = in.eq;
        prep_next.neg_re = neg_re;
        prep_next.neg_im = neg_im;
        prep_next.den    = in.den;
        prep_next.q_re   = '0;
        prep_next.q_im   = '0;
        prep_next.big_re = 1'b0;
        prep_next.big_im = 1'b0;
        if (div_ok)
        begin
            prep_next.rem_re = cau_pkg::NUM_W'(mag_re) << cau_pkg::FRAC_BITS;
            prep_next.rem_im = cau_pkg::NUM_W'(mag_im) << cau_pkg::FRAC_BITS;
            prep_next.big_re = cau_pkg::CMP_W'(prep_next.rem_re) >= lim;
            prep_next.big_im = cau_pkg::CMP_W'(prep_next.rem_im) >= lim;
        end
        else if (in.func == cau_pkg::OP_MUL)
        begin
            prep_next.rem_re = cau_pkg::NUM_W'(mag_re >> cau_pkg::FRAC_BITS);
            prep_next.rem_im = cau_pkg::NUM_W'(mag_im >> cau_pkg::FRAC_BITS);
        end
        else
        begin
            prep_next.rem_re = cau_pkg::NUM_W'(mag_re);
            prep_next.rem_im = cau_pkg::NUM_W'(mag_im);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg[0].valid <= 1'b0;
        end
        else if (en)
        begin
            st_reg[0] <= prep_next;
        end
    end

    // One restoring step per stage, quotient msb first
    for (genvar k = 0; k < cau_pkg::Q_BITS; k++)
    begin : g_step
        localparam int J = cau_pkg::Q_BITS - 1 - k;
        cau_pkg::step_t            s_next;
        logic [cau_pkg::CMP_W-1:0] trial;

        always_comb
        begin
            s_next = st_reg[k];
            trial  = cau_pkg::CMP_W'(st_reg[k].den) << J;
            if (st_reg[k].is_div && !st_reg[k].big_re
                && cau_pkg::CMP_W'(st_reg[k].rem_re) >= trial)
            begin
                s_next.rem_re  = st_reg[k].rem_re - trial[cau_pkg::NUM_W-1:0];
                s_next.q_re[J] = 1'b1;
            end
            if (st_reg[k].is_div && !st_reg[k].big_im
                && cau_pkg::CMP_W'(st_reg[k].rem_im) >= trial)
            begin
                s_next.rem_im  = st_reg[k].rem_im - trial[cau_pkg::NUM_W-1:0];
                s_next.q_im[J] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                st_reg[k+1].valid <= 1'b0;
            end
            else if (en)
            begin
                st_reg[k+1] <= s_next;
            end
        end
    end

    assign out = st_reg[cau_pkg::Q_BITS];

endmodule

FILE: src/complex_arithmetic_unit.sv
// Channel   Dir  tdata                             tuser
// s_axis    in   a_re, a_im, b_re, b_im (128 b)    func (3 b)
// m_axis    out  res_re, res_im (64 b)             is_equal, overflow, div_by_zero
//
// One item enters per cycle while the output is not stalled; every operation passes
// 37 register stages: two multiply/sum stages, one scaling stage, 33 quotient-bit
// stages (one restoring subtract each) and the output register.
// rst_n clears all valid bits asynchronously.
// A stall at the output freezes the whole pipeline; s_tready follows it.
module complex_arithmetic_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,   // a_re, a_im, b_re, b_im
    input  logic [2:0]    s_tuser,   // func
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [63:0]   m_tdata,   // res_re, res_im
    output logic [2:0]    m_tuser    // is_equal, overflow, div_by_zero
);

    logic                          en;
    cau_pkg::front_t               front;
    cau_pkg::step_t                fin;
    logic [cau_pkg::MAG_W-1:0]     val_re, val_im;
    logic [cau_pkg::DATA_W:0]      sat_re, sat_im;
    logic                          out_valid_reg;
    logic [63:0]                   out_data_reg, out_data_next;
    logic [2:0]                    out_user_reg, out_user_next;

    // Advance everything unless the output item is held
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    cau_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .func     (s_tuser),
        .a_re     (s_tdata[31:0]),
        .a_im     (s_tdata[63:32]),
        .b_re     (s_tdata[95:64]),
        .b_im     (s_tdata[127:96]),
        .out      (front)
    );

    cau_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .in    (front),
        .out   (fin)
    );

    // Saturate and form the flags
    always_comb
    begin
        if (fin.is_div)
        begin
            val_re = fin.big_re ? '1 : cau_pkg::MAG_W'(fin.q_re);
            val_im = fin.big_im ? '1 : cau_pkg::MAG_W'(fin.q_im);
        end
        else
        begin
            val_re = fin.rem_re[cau_pkg::MAG_W-1:0];
            val_im = fin.rem_im[cau_pkg::MAG_W-1:0];
        end
        sat_re = cau_pkg::saturate(fin.neg_re, val_re);
        sat_im = cau_pkg::saturate(fin.neg_im, val_im);
        out_data_next = {sat_im[cau_pkg::DATA_W-1:0], sat_re[cau_pkg::DATA_W-1:0]};
        out_user_next = {fin.dz, sat_re[cau_pkg::DATA_W] | sat_im[cau_pkg::DATA_W], fin.eq};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= fin.valid;
            out_data_reg  <= out_data_next;
            out_user_reg  <= out_user_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

FILE: src/cau_checker.sv
module cau_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [63:0]  m_tdata,
    input logic [2:0]   m_tuser
);

    // Hold a stalled output item
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output item changed while stalled");

    // Accept input whenever no output item is pending
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // Zero divisor gives zero and no overflow
    a_dz: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> m_tdata == 64'd0 && !m_tuser[1] && !m_tuser[0])
        else $error("bad divide-by-zero result");

    // Compare gives zero data and no overflow
    a_eq: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == 64'd0 && !m_tuser[1])
        else $error("bad compare result");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: tb/cau_checker.sv
module cau_scoreboard (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [127:0] s_tdata,
    input  logic [2:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [63:0]  m_tdata,
    input  logic [2:0]   m_tuser,
    output int           fail_count,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] res_re;
        logic [31:0] res_im;
        logic        is_equal;
        logic        overflow;
        logic        div_by_zero;
    } cplx_result_t;

    cplx_result_t result_q[$];

    // Clamp an exact value to 32 bits, flag overflow
    function automatic logic [31:0] clamp32(input logic signed [95:0] v, inout logic ovf);
        if (v > 96'sh7FFF_FFFF)
        begin
            ovf = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -96'sh8000_0000)
        begin
            ovf = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // Exact complex arithmetic, truncation toward zero, then saturation
    function automatic cplx_result_t complex_op(input logic [2:0] op, input logic [127:0] data);
        logic signed [95:0] a;
        logic signed [95:0] b;
        logic signed [95:0] c;
        logic signed [95:0] d;
        logic signed [95:0] re_w;
        logic signed [95:0] im_w;
        logic signed [95:0] den;
        logic               ovf;
        cplx_result_t       r;
        a = $signed(data[31:0]);
        b = $signed(data[63:32]);
        c = $signed(data[95:64]);
        d = $signed(data[127:96]);
        r = '0;
        ovf = 1'b0;
        case (op)
            cau_pkg::OP_ADD:
            begin
                r.res_re = clamp32(a + c, ovf);
                r.res_im = clamp32(b + d, ovf);
            end
            cau_pkg::OP_SUB:
            begin
                r.res_re = clamp32(a - c, ovf);
                r.res_im = clamp32(b - d, ovf);
            end
            cau_pkg::OP_MUL:
            begin
                re_w = (a * c - b * d) / 96'sd65536;
                im_w = (a * d + b * c) / 96'sd65536;
                r.res_re = clamp32(re_w, ovf);
                r.res_im = clamp32(im_w, ovf);
            end
            cau_pkg::OP_DIV:
            begin
                den = c * c + d * d;
                if (den == 0)
                    r.div_by_zero = 1'b1;
                else
                begin
                    re_w = ((a * c + b * d) * 96'sd65536) / den;
                    im_w = ((b * c - a * d) * 96'sd65536) / den;
                    r.res_re = clamp32(re_w, ovf);
                    r.res_im = clamp32(im_w, ovf);
                end
            end
            cau_pkg::OP_CMP:
                r.is_equal = (a == c) && (b == d);
            default:
                r = '0;
        endcase
        r.overflow = ovf;
        return r;
    endfunction

    assign pending = result_q.size();

    initial
        fail_count = 0;

    // Predict on input items, compare on output items
    always @(posedge clk)
    begin
        cplx_result_t want;
        cplx_result_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                result_q.push_back(complex_op(s_tuser, s_tdata));
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[31:0], m_tdata[63:32], m_tuser[0], m_tuser[1], m_tuser[2]};
                if (result_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
                    fail_count++;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (got.res_re !== want.res_re)
                    begin
                        $display("%0t: res_re expected %h actual %h", $realtime,
                                 want.res_re, got.res_re);
                        fail_count++;
                    end
                    if (got.res_im !== want.res_im)
                    begin
                        $display("%0t: res_im expected %h actual %h", $realtime,
                                 want.res_im, got.res_im);
                        fail_count++;
                    end
                    if (got.is_equal !== want.is_equal)
                    begin
                        $display("%0t: is_equal expected %b actual %b", $realtime,
                                 want.is_equal, got.is_equal);
                        fail_count++;
                    end
                    if (got.overflow !== want.overflow)
                    begin
                        $display("%0t: overflow expected %b actual %b", $realtime,
                                 want.overflow, got.overflow);
                        fail_count++;
                    end
                    if (got.div_by_zero !== want.div_by_zero)
                    begin
                        $display("%0t: div_by_zero expected %b actual %b", $realtime,
                                 want.div_by_zero, got.div_by_zero);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

FILE: tb/tb_complex_arithmetic_unit.sv
module tb_complex_arithmetic_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM   = 780;
    localparam int IDLE_LIMIT = 3000;
    localparam int LONG_HOLD  = 200;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic [2:0]   m_tuser;
    int           fail_count;
    int           pending;
    int           idle_cycles = 0;
    int           rx_count = 0;

    always #5 clk = ~clk;

    complex_arithmetic_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    cau_scoreboard u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Offer one item after a random gap, hold until accepted
    task automatic send_op(input logic [2:0] op, input logic [31:0] a_re, input logic [31:0] a_im,
                           input logic [31:0] b_re, input logic [31:0] b_im);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {b_im, b_re, a_im, a_re};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Pick an operand part, weighted toward edges and small values
    function automatic logic [31:0] pick_part();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'($signed($urandom_range(0, 2 * 65536 * 8)) - 65536 * 8);
            4: return 32'($signed($urandom_range(0, 512)) - 256);
            5: return $urandom() >> $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    // Accept results with random stalls, one long hold-off early in the run
    initial
    begin
        int wait_n;
        @(posedge clk iff rst_n);
        forever
        begin
            if (rx_count == 120)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                rx_count++;
            end
            wait_n = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 8);
            if (wait_n > 0)
            begin
                m_tready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            rx_count++;
        end
    end

    // End the run when no item moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_complex_arithmetic_unit: FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [2:0] op;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every operation, zero divisor, unused codes
        send_op(cau_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_op(cau_pkg::OP_ADD, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000, 32'h0000_0001);
        send_op(cau_pkg::OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_op(cau_pkg::OP_SUB, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0);
        send_op(cau_pkg::OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_op(cau_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_op(cau_pkg::OP_MUL, 32'h0002_0000, 32'hFFFF_8000, 32'h0001_8000, 32'h0000_4000);
        send_op(cau_pkg::OP_MUL, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF);
        send_op(cau_pkg::OP_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);
        send_op(cau_pkg::OP_DIV, 32'h0, 32'h0, 32'h0, 32'h0);
        send_op(cau_pkg::OP_DIV, 32'h0006_0000, 32'h0002_0000, 32'h0002_0000, 32'h0);
        send_op(cau_pkg::OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0);
        send_op(cau_pkg::OP_DIV, 32'h0001_0000, 32'h0, 32'h0003_0000, 32'h0);
        send_op(cau_pkg::OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_op(cau_pkg::OP_DIV, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000);
        send_op(cau_pkg::OP_CMP, 32'h1234_5678, 32'h8000_0000, 32'h1234_5678, 32'h8000_0000);
        send_op(cau_pkg::OP_CMP, 32'h1234_5678, 32'h0, 32'h1234_5679, 32'h0);
        send_op(cau_pkg::OP_CMP, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        send_op(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(3'd6, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_op(3'd7, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);

        // Random: mostly valid codes, a few unused, zero divisors and equal pairs
        for (int i = 0; i < N_RANDOM; i++)
        begin
            logic [31:0] p0;
            logic [31:0] p1;
            logic [31:0] p2;
            logic [31:0] p3;
            if (i == N_RANDOM / 2)
            begin
                s_tvalid <= 1'b0;
                wait (pending == 0);
                @(posedge clk);
            end
            op = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
            p0 = pick_part();
            p1 = pick_part();
            p2 = pick_part();
            p3 = pick_part();
            if (op == cau_pkg::OP_DIV && $urandom_range(0, 9) == 0)
            begin
                p2 = '0;
                p3 = '0;
            end
            if (op == cau_pkg::OP_CMP && $urandom_range(0, 1) == 0)
            begin
                p2 = p0;
                p3 = $urandom_range(0, 1) ? p1 : p1 ^ (32'h1 << $urandom_range(0, 31));
            end
            send_op(op, p0, p1, p2, p3);
        end
        s_tvalid <= 1'b0;

        // Drain, then allow the pipeline latency to pass
        wait (pending == 0);
        repeat (60) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_complex_arithmetic_unit: PASS");
        else
            $display("tb_complex_arithmetic_unit: FAIL");
        $finish;
    end

endmodule
